// File: rtl/ovd_pkg.sv
// ============================================================================
// ovd_pkg
// Shared types and constants of the ordered prefix varint decoder: field
// widths, result status codes, code lengths and shortest-form limits.
// ============================================================================
package ovd_pkg;

    // payload widths
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 3;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_NONCANON = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    // code lengths in bytes
    localparam logic [COUNT_W-1:0] LEN_1 = 4'd1;
    localparam logic [COUNT_W-1:0] LEN_2 = 4'd2;
    localparam logic [COUNT_W-1:0] LEN_3 = 4'd3;
    localparam logic [COUNT_W-1:0] LEN_4 = 4'd4;
    localparam logic [COUNT_W-1:0] LEN_6 = 4'd6;
    localparam logic [COUNT_W-1:0] LEN_9 = 4'd9;

    // leading byte of the nine-byte forms
    localparam logic [BYTE_W-1:0] LEAD_U9 = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD_N9 = 8'h0F;

    // smallest value that needs the unsigned form of each length
    localparam logic [VALUE_W-1:0] LIM_U2 = 64'h0000_0000_0000_0040;
    localparam logic [VALUE_W-1:0] LIM_U4 = 64'h0000_0000_0000_2000;
    localparam logic [VALUE_W-1:0] LIM_U6 = 64'h0000_0000_1000_0000;
    localparam logic [VALUE_W-1:0] LIM_U9 = 64'h0000_0800_0000_0000;

    // negative forms: values at or above these fit a shorter form
    localparam logic [VALUE_W-1:0] LIM_N3 = 64'hFFFF_FFFF_FFFF_FFC0;
    localparam logic [VALUE_W-1:0] LIM_N6 = 64'hFFFF_FFFF_FFE0_0000;
    localparam logic [VALUE_W-1:0] LIM_N9 = 64'hFFFF_F000_0000_0000;

endpackage

// File: rtl/ovd_stream_if.sv
// ============================================================================
// ovd_stream_if
// Valid/ready channels of the decoder: the encoded byte stream going in and
// the decoded results coming out.
// ============================================================================
interface ovd_byte_if;
    logic                      valid;
    logic                      ready;
    logic [ovd_pkg::BYTE_W-1:0] data_byte;
    logic                      buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface ovd_result_if;
    logic                        valid;
    logic                        ready;
    logic [ovd_pkg::VALUE_W-1:0]  value;
    logic [ovd_pkg::COUNT_W-1:0]  byte_count;
    logic [ovd_pkg::STATUS_W-1:0] status;

    modport source (output valid, output value, output byte_count, output status,
                    input ready);
    modport sink   (input valid, input value, input byte_count, input status,
                    output ready);
endinterface

// File: rtl/ordered_varint_decoder_unit.sv
// ============================================================================
// ordered_varint_decoder_unit
// Byte-serial decoder for order-preserving prefix-coded 64-bit integers.
// ============================================================================
// One byte request is taken per clock cycle, back to back, for as long as the
// result register is empty or being drained in the same cycle. Each byte goes
// through a single pass of logic that updates the code state (accumulator,
// bytes remaining, code length, sign form) and, when a code completes or
// fails, loads the result register; a result appears in the cycle after its last
// byte and holds until taken. Codes are 1, 2, 3, 4, 6 or 9 bytes long; errors
// report value zero and the bytes taken, and the next byte is read as a new
// leading byte. signed_mode is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while no code is in progress (not enforced by the block);
// a mid-code change affects only the out-of-range check of the final byte.
module ordered_varint_decoder_unit (
    input  logic               clk,
    input  logic               rst_n,
    ovd_byte_if.sink           code_byte,
    ovd_result_if.source       result,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);

    localparam int VW = ovd_pkg::VALUE_W;
    localparam int BW = ovd_pkg::BYTE_W;
    localparam int CW = ovd_pkg::COUNT_W;

    // code state
    logic [VW-1:0] acc_reg, acc_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] len_reg, len_next;
    logic          neg_reg, neg_next;
    logic          signed_mode_reg;

    // result register
    logic                         out_valid_reg;
    logic [VW-1:0]                out_value_reg;
    logic [CW-1:0]                out_count_reg;
    ovd_pkg::status_t             out_status_reg;

    logic                         accept;
    logic                         emit;
    logic [VW-1:0]                emit_value;
    logic [CW-1:0]                emit_count;
    ovd_pkg::status_t             emit_status;

    logic [BW-1:0]                b;
    logic [VW-1:0]                shifted;
    logic [CW-1:0]                rem_dec;
    logic [VW-1:0]                lim_u;
    logic [VW-1:0]                lim_n;

    assign code_byte.ready = !out_valid_reg || result.ready;
    assign accept          = code_byte.valid && code_byte.ready;
    assign b               = code_byte.data_byte;
    assign shifted         = {acc_reg[VW-BW-1:0], b};
    assign rem_dec         = rem_reg - CW'(1);

    // shortest-form limits for the code in progress
    always_comb
    begin
        case (len_reg)
            ovd_pkg::LEN_2: lim_u = ovd_pkg::LIM_U2;
            ovd_pkg::LEN_4: lim_u = ovd_pkg::LIM_U4;
            ovd_pkg::LEN_6: lim_u = ovd_pkg::LIM_U6;
            default:        lim_u = ovd_pkg::LIM_U9;
        endcase
        case (len_reg)
            ovd_pkg::LEN_3: lim_n = ovd_pkg::LIM_N3;
            ovd_pkg::LEN_6: lim_n = ovd_pkg::LIM_N6;
            default:        lim_n = ovd_pkg::LIM_N9;
        endcase
    end

    // per-byte decode step
    always_comb
    begin
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        len_next    = len_reg;
        neg_next    = neg_reg;
        emit        = 1'b0;
        emit_value  = '0;
        emit_count  = ovd_pkg::LEN_1;
        emit_status = ovd_pkg::ST_OK;

        if (accept)
        begin
            if (rem_reg == '0)
            begin
                // leading byte: pick length and sign form
                if (b[7:6] == 2'b10)
                begin
                    emit       = 1'b1;
                    emit_value = {{(VW-6){1'b0}}, b[5:0]};
                end
                else if (signed_mode_reg && b[7:6] == 2'b01)
                begin
                    emit       = 1'b1;
                    emit_value = {{(VW-6){1'b1}}, b[5:0]};
                end
                else
                begin
                    if (b[7:5] == 3'b110)
                    begin
                        len_next = ovd_pkg::LEN_2;
                        acc_next = {{(VW-5){1'b0}}, b[4:0]};
                        neg_next = 1'b0;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        len_next = ovd_pkg::LEN_4;
                        acc_next = {{(VW-4){1'b0}}, b[3:0]};
                        neg_next = 1'b0;
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        len_next = ovd_pkg::LEN_6;
                        acc_next = {{(VW-3){1'b0}}, b[2:0]};
                        neg_next = 1'b0;
                    end
                    else if (b == ovd_pkg::LEAD_U9)
                    begin
                        len_next = ovd_pkg::LEN_9;
                        acc_next = '0;
                        neg_next = 1'b0;
                    end
                    else if (signed_mode_reg && b[7:5] == 3'b001)
                    begin
                        len_next = ovd_pkg::LEN_3;
                        acc_next = {{(VW-5){1'b1}}, b[4:0]};
                        neg_next = 1'b1;
                    end
                    else if (signed_mode_reg && b[7:4] == 4'b0001)
                    begin
                        len_next = ovd_pkg::LEN_6;
                        acc_next = {{(VW-4){1'b1}}, b[3:0]};
                        neg_next = 1'b1;
                    end
                    else if (signed_mode_reg && b == ovd_pkg::LEAD_N9)
                    begin
                        len_next = ovd_pkg::LEN_9;
                        acc_next = '0;
                        neg_next = 1'b1;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        emit_status = ovd_pkg::ST_BAD_LEAD;
                    end

                    if (!emit)
                    begin
                        if (code_byte.buffer_end)
                        begin
                            emit        = 1'b1;
                            emit_status = ovd_pkg::ST_TRUNC;
                        end
                        else
                        begin
                            rem_next = len_next - CW'(1);
                        end
                    end
                end
            end
            else
            begin
                // continuation byte
                acc_next = shifted;
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    emit       = 1'b1;
                    emit_count = len_reg;
                    if (neg_reg)
                    begin
                        if ($signed(shifted) >= $signed(lim_n))
                            emit_status = ovd_pkg::ST_NONCANON;
                        else
                            emit_value = shifted;
                    end
                    else
                    begin
                        if (shifted < lim_u)
                            emit_status = ovd_pkg::ST_NONCANON;
                        else if (signed_mode_reg && shifted[VW-1])
                            emit_status = ovd_pkg::ST_RANGE;
                        else
                            emit_value = shifted;
                    end
                end
                else if (code_byte.buffer_end)
                begin
                    emit        = 1'b1;
                    emit_count  = len_reg - rem_dec;
                    emit_status = ovd_pkg::ST_TRUNC;
                end
            end

            // any result ends the code
            if (emit)
            begin
                acc_next = '0;
                rem_next = '0;
                len_next = '0;
                neg_next = 1'b0;
            end
        end
    end

    // code state and mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg         <= '0;
            rem_reg         <= '0;
            len_reg         <= '0;
            neg_reg         <= 1'b0;
            signed_mode_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            len_reg <= len_next;
            neg_reg <= neg_next;
            if (cfg_wr_en)
                signed_mode_reg <= cfg_wr_data;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg  <= emit_value;
            out_count_reg  <= emit_count;
            out_status_reg <= emit_status;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.value      = out_value_reg;
    assign result.byte_count = out_count_reg;
    assign result.status     = out_status_reg;

endmodule
